### design/rbpf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbpf_pkg
// Shared types and constants of the ring buffer packet framer.
// ----------------------------------------------------------------------------
package rbpf_pkg;

   localparam int FA_W        = 5;
   localparam int FRAME_DEPTH = 32;
   localparam int LEN_W       = 5;

   localparam logic [7:0] HDR_DATA      = 8'hA0;
   localparam logic [7:0] HDR_KEEPALIVE = 8'h60;

   typedef enum logic [1:0] {
      OP_BYTE = 2'd0,
      OP_IDLE = 2'd1,
      OP_POLL = 2'd2,
      OP_NONE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_GATHER,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic            en;
      logic [FA_W-1:0] addr;
      logic [7:0]      data;
   } fb_wr_type;

   typedef struct packed {
      logic            en;
      logic [FA_W-1:0] addr;
   } fb_rd_type;

endpackage : rbpf_pkg
`default_nettype wire

### design/rbpf_frame_buf.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbpf_frame_buf
// Frame byte memory, one write and one registered read port. Per-entry valid
// bits make entries read as zero until first written after reset.
// ----------------------------------------------------------------------------
module rbpf_frame_buf (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire rbpf_pkg::fb_wr_type  wr,
   input  wire rbpf_pkg::fb_rd_type  rd,
   output logic [7:0]                rd_data
);
   import rbpf_pkg::*;

   logic [7:0]             mem [FRAME_DEPTH];
   logic [FRAME_DEPTH-1:0] vld_ff;
   logic [7:0]             q_ff;
   logic                   qv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr.en) begin
         vld_ff[wr.addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         q_ff  <= mem[rd.addr];
         qv_ff <= vld_ff[rd.addr];
      end
   end

   assign rd_data = qv_ff ? q_ff : 8'h00;

endmodule : rbpf_frame_buf
`default_nettype wire

### design/ring_buffer_packet_framer_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ring_buffer_packet_framer_top
// Ring buffer of serial bytes framed into fixed-length packets on poll.
// ----------------------------------------------------------------------------
// Byte and line-idle requests leave the framer in its idle state. A poll that
// sends a data frame first gathers its len payload bytes through the single
// read port of the ring memory, one per cycle, then streams FRAME_BYTES bytes,
// header and checksum from registers and the rest out of the frame memory,
// one per cycle while the receiver takes them; a receiver stall holds the
// stream. The input is held off through the gather and the stream; a keepalive
// frame skips the gather. Requests are taken only between frames. The frame
// memory reads as zero until written, through valid bits, so no clearing
// pass follows reset.
module ring_buffer_packet_framer_top #(
   parameter int RING_DEPTH  = 256,
   parameter int MAX_PAYLOAD = 30,
   parameter int FRAME_BYTES = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // data_byte[7:0], tx_empty[8], zero pad
   input  wire logic [1:0]  req_tuser,   // op[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // frame_byte[7:0], byte_index[12:8], zero pad
   output logic             rsp_tlast,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_data     // keepalive_enable
);
   import rbpf_pkg::*;

   localparam int PTR_W  = $clog2(RING_DEPTH);
   localparam int KCNT_W = $clog2(FRAME_BYTES + 1);
   localparam int CAP    = (MAX_PAYLOAD < FRAME_BYTES - 2) ? MAX_PAYLOAD : FRAME_BYTES - 2;

   state_type         state_ff, state_in;
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic              idle_ff, idle_in;
   logic              keep_ff;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [LEN_W-1:0]  iss_ff, iss_in;
   logic              pend_ff, pend_in;
   logic [LEN_W-1:0]  pidx_ff, pidx_in;
   logic [7:0]        hdr_ff, hdr_in;
   logic [7:0]        sum_ff, sum_in;
   logic [KCNT_W-1:0] kiss_ff, kiss_in;
   logic              f_ff, f_in;
   logic [FA_W-1:0]   fidx_ff, fidx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_byte_ff, rsp_byte_in;
   logic [FA_W-1:0]   rsp_idx_ff, rsp_idx_in;
   logic              rsp_last_ff, rsp_last_in;

   logic [7:0]        ring_mem [RING_DEPTH];
   logic [7:0]        ring_q_ff;
   logic              ring_wr_en;
   logic              ring_rd_en;

   fb_wr_type         fb_wr;
   fb_rd_type         fb_rd;
   logic [7:0]        fb_rd_data;

   op_type            req_op;
   logic [7:0]        req_byte;
   logic              req_txe;
   logic              req_acc;
   logic [PTR_W:0]    diff;
   logic [PTR_W-1:0]  cnt;
   logic              over;
   logic              out_free;
   logic              load;
   logic              issue;
   logic [7:0]        sel_byte;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      ptr_next = (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign req_op     = op_type'(req_tuser);
   assign req_byte   = req_tdata[7:0];
   assign req_txe    = req_tdata[8];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign diff = (wr_ptr_ff >= rd_ptr_ff)
               ? {1'b0, wr_ptr_ff} - {1'b0, rd_ptr_ff}
               : {1'b0, wr_ptr_ff} + (PTR_W + 1)'(RING_DEPTH) - {1'b0, rd_ptr_ff};
   assign cnt  = diff[PTR_W-1:0];
   assign over = cnt > PTR_W'(MAX_PAYLOAD);

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign load     = f_ff && out_free;

   always_comb begin
      unique case (fidx_ff)
         FA_W'(0): sel_byte = hdr_ff;
         FA_W'(1): sel_byte = sum_ff;
         default:  sel_byte = fb_rd_data;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      wr_ptr_in    = wr_ptr_ff;
      rd_ptr_in    = rd_ptr_ff;
      idle_in      = idle_ff;
      len_in       = len_ff;
      iss_in       = iss_ff;
      pend_in      = 1'b0;
      pidx_in      = pidx_ff;
      hdr_in       = hdr_ff;
      sum_in       = sum_ff;
      kiss_in      = kiss_ff;
      f_in         = f_ff;
      fidx_in      = fidx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_last_in  = rsp_last_ff;
      ring_wr_en   = 1'b0;
      ring_rd_en   = 1'b0;
      issue        = 1'b0;
      fb_wr        = '0;
      fb_rd        = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               case (req_op)
                  OP_BYTE: begin
                     ring_wr_en = 1'b1;
                     wr_ptr_in  = ptr_next(wr_ptr_ff);
                  end
                  OP_IDLE: begin
                     idle_in = 1'b1;
                  end
                  OP_POLL: begin
                     if (req_txe) begin
                        if (over || idle_ff) begin
                           if (!over) begin
                              idle_in = 1'b0;
                           end
                           len_in   = (cnt > PTR_W'(CAP)) ? LEN_W'(CAP) : LEN_W'(cnt);
                           hdr_in   = HDR_DATA | {3'b000, len_in};
                           sum_in   = 8'h00;
                           iss_in   = '0;
                           state_in = ST_GATHER;
                        end else if (keep_ff) begin
                           hdr_in   = HDR_KEEPALIVE;
                           sum_in   = 8'h00;
                           kiss_in  = '0;
                           f_in     = 1'b0;
                           state_in = ST_EMIT;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_GATHER: begin
            ring_rd_en = (iss_ff != len_ff);
            if (ring_rd_en) begin
               rd_ptr_in = ptr_next(rd_ptr_ff);
               iss_in    = iss_ff + LEN_W'(1);
               pend_in   = 1'b1;
               pidx_in   = iss_ff;
            end
            if (pend_ff) begin
               fb_wr.en   = 1'b1;
               fb_wr.addr = FA_W'(pidx_ff) + FA_W'(2);
               fb_wr.data = ring_q_ff;
               sum_in     = sum_ff + ring_q_ff;
            end
            if (!ring_rd_en && !pend_ff) begin
               kiss_in  = '0;
               f_in     = 1'b0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            issue = (kiss_ff != KCNT_W'(FRAME_BYTES)) && (!f_ff || load);
            if (issue) begin
               fb_rd.en   = 1'b1;
               fb_rd.addr = FA_W'(kiss_ff);
               fidx_in    = FA_W'(kiss_ff);
               kiss_in    = kiss_ff + KCNT_W'(1);
               f_in       = 1'b1;
            end else if (load) begin
               f_in = 1'b0;
            end
            if (!f_ff && kiss_ff == KCNT_W'(FRAME_BYTES)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = sel_byte;
         rsp_idx_in   = fidx_ff;
         rsp_last_in  = (fidx_ff == FA_W'(FRAME_BYTES - 1));
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         idle_ff      <= 1'b0;
         keep_ff      <= 1'b0;
         pend_ff      <= 1'b0;
         f_ff         <= 1'b0;
         rsp_valid_ff <= 1'b0;
         len_ff       <= '0;
         iss_ff       <= '0;
         kiss_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         idle_ff      <= idle_in;
         pend_ff      <= pend_in;
         f_ff         <= f_in;
         rsp_valid_ff <= rsp_valid_in;
         len_ff       <= len_in;
         iss_ff       <= iss_in;
         kiss_ff      <= kiss_in;
         if (csr_valid && csr_ready) begin
            keep_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      pidx_ff     <= pidx_in;
      hdr_ff      <= hdr_in;
      sum_ff      <= sum_in;
      fidx_ff     <= fidx_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_last_ff <= rsp_last_in;
   end

   // ring memory
   always_ff @(posedge clock) begin
      if (ring_wr_en) begin
         ring_mem[wr_ptr_ff] <= req_byte;
      end
      if (ring_rd_en) begin
         ring_q_ff <= ring_mem[rd_ptr_ff];
      end
   end

   rbpf_frame_buf u_frame_buf (
      .clock   (clock),
      .reset   (reset),
      .wr      (fb_wr),
      .rd      (fb_rd),
      .rd_data (fb_rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_idx_ff, rsp_byte_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule : ring_buffer_packet_framer_top
`default_nettype wire
